// File: src/rzv_pkg.sv
// ----------------------------------------------------------------------------
// rzv_pkg
// Widths and constants shared by the rotated zigzag varint decoder files.
// ----------------------------------------------------------------------------
package rzv_pkg;

  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 3;
  localparam int GROUP_W  = 7;
  localparam int INDEX_W  = 3;

  // Position of the continuation mark within a byte.
  localparam int CONT_BIT = 7;
  // Bit of the first byte that carries group bit 0.
  localparam int ROT_BIT  = 6;

  // Index of the last byte position of a value.
  localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd4;
  localparam logic [INDEX_W-1:0] FIRST_INDEX = 3'd0;

  localparam logic [COUNT_W-1:0] MAX_COUNT = 3'd5;

endpackage

// File: src/rzv_byte_if.sv
// ----------------------------------------------------------------------------
// rzv_byte_if
// Valid/ready channel that carries one raw byte of the encoded stream.
// ----------------------------------------------------------------------------
interface rzv_byte_if
  import rzv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: src/rzv_result_if.sv
// ----------------------------------------------------------------------------
// rzv_result_if
// Valid/ready channel that carries one decoded value with its byte count
// and overflow flag.
// ----------------------------------------------------------------------------
interface rzv_result_if
  import rzv_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic        [COUNT_W-1:0] byte_count;
  logic                      overflow;

  modport source (output valid, output value, output byte_count, output overflow,
                  input ready);
  modport sink   (input valid, input value, input byte_count, input overflow,
                  output ready);
endinterface

// File: src/rotated_zigzag_varint_decoder.sv
// ----------------------------------------------------------------------------
// rotated_zigzag_varint_decoder
// Decodes 32-bit zigzag varints from a byte stream, first byte rotated.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle and keeps that rate for any
// stream, stalling only when the result side holds back. A byte passes an
// input register and then the group merge and zigzag logic into the result
// register, from which the value is offered. A value ends on a byte with
// bit 7 clear, or on a fifth byte in any case; a fifth byte with bit 7 set
// flags overflow. Bytes that do not end a value produce no item.
module rotated_zigzag_varint_decoder
  import rzv_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rzv_byte_if.sink      bytes,
  rzv_result_if.source  results
);

  // Input register.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;

  // Decode state.
  logic [INDEX_W-1:0] group_index;
  logic [VALUE_W-1:0] accumulator;

  // Result register.
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic        [COUNT_W-1:0] out_count;
  logic                      out_overflow;

  logic               advance;
  logic               more;
  logic               emit;
  logic [INDEX_W-1:0] idx;
  logic [GROUP_W-1:0] group;
  logic [VALUE_W-1:0] acc_base;
  logic [VALUE_W-1:0] shifted;
  logic [VALUE_W-1:0] word;
  logic [VALUE_W-1:0] decoded;

  assign advance = s1_valid && (!out_valid || results.ready);
  assign bytes.ready = !s1_valid || advance;

  always_comb begin
    more = s1_byte[CONT_BIT];
    idx  = (group_index > LAST_INDEX) ? LAST_INDEX : group_index;
    if (idx == FIRST_INDEX) begin
      group    = {s1_byte[ROT_BIT-1:0], s1_byte[ROT_BIT]};
      acc_base = '0;
    end else begin
      group    = s1_byte[GROUP_W-1:0];
      acc_base = accumulator;
    end
    // The fifth group keeps only its low four bits.
    case (idx)
      3'd0:    shifted = {{(VALUE_W-GROUP_W){1'b0}}, group};
      3'd1:    shifted = {{(VALUE_W-2*GROUP_W){1'b0}}, group, {GROUP_W{1'b0}}};
      3'd2:    shifted = {{(VALUE_W-3*GROUP_W){1'b0}}, group, {(2*GROUP_W){1'b0}}};
      3'd3:    shifted = {{(VALUE_W-4*GROUP_W){1'b0}}, group, {(3*GROUP_W){1'b0}}};
      default: shifted = {group[VALUE_W-4*GROUP_W-1:0], {(4*GROUP_W){1'b0}}};
    endcase
    word    = acc_base | shifted;
    decoded = {1'b0, word[VALUE_W-1:1]} ^ {VALUE_W{word[0]}};
    emit    = !(more && (idx < LAST_INDEX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.ready && bytes.valid) begin
      s1_byte <= bytes.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_index <= FIRST_INDEX;
      accumulator <= '0;
    end else if (advance) begin
      if (emit) begin
        group_index <= FIRST_INDEX;
        accumulator <= '0;
      end else begin
        group_index <= idx + 3'd1;
        accumulator <= word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_value    <= decoded;
      out_count    <= idx + 3'd1;
      out_overflow <= more;
    end
  end

  assign results.valid      = out_valid;
  assign results.value      = out_value;
  assign results.byte_count = out_count;
  assign results.overflow   = out_overflow;

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    group_index <= LAST_INDEX)
    else $error("group index beyond last byte position");

  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_overflow |-> out_count == MAX_COUNT)
    else $error("overflow flagged on a value shorter than five bytes");

  a_emit_restart: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> group_index == FIRST_INDEX && out_valid)
    else $error("finished value did not restart the decode");

  a_continue_step: assert property (@(posedge clk) disable iff (rst)
    advance && !emit |=> group_index == $past(idx) + 3'd1)
    else $error("group index did not step on a continued byte");

endmodule
